[hw/rtl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int ROW_COUNT    = 25;
  localparam int COLUMN_COUNT = 80;
  localparam int CELL_COUNT   = ROW_COUNT * COLUMN_COUNT;

  localparam int ROW_W  = $clog2(ROW_COUNT);
  localparam int ROW_W1 = ROW_W + 1;
  localparam int COL_W  = $clog2(COLUMN_COUNT);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Port field widths
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int CLR_W   = 4;
  localparam int PROW_W  = 5;
  localparam int PCOL_W  = 7;
  localparam int OFF_W   = 11;
  localparam int CFG_IDX_W = 1;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  // Special character codes
  localparam logic [CHAR_W-1:0] CHAR_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;

  // Colours after reset
  localparam logic [CLR_W-1:0] RST_FG = 4'd7;
  localparam logic [CLR_W-1:0] RST_BG = 4'd0;

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Back-end operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
  localparam logic [OP_W-1:0] OP_PUT   = 3'd1;
  localparam logic [OP_W-1:0] OP_NL    = 3'd2;
  localparam logic [OP_W-1:0] OP_CR    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

  typedef struct packed {
    logic [CLR_W-1:0]  bg;
    logic [CLR_W-1:0]  fg;
    logic [CHAR_W-1:0] ch;
  } cell_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [CLR_W-1:0]  fg;
    logic [CLR_W-1:0]  bg;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  function automatic cell_t make_cell(input logic [CHAR_W-1:0] ch,
                                      input logic [CLR_W-1:0] fg,
                                      input logic [CLR_W-1:0] bg);
    cell_t c;
    c.ch = ch;
    c.fg = fg;
    c.bg = bg;
    return c;
  endfunction

  // row * COLUMN_COUNT + col
  function automatic logic [ADDR_W-1:0] lin_index(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMN_COUNT) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tcw_front.sv]
`default_nettype none

module tcw_front import tcw_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CLR_W-1:0]     cfg_data,
  // input word
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [MODE_W-1:0]    in_mode,
  input  wire logic [CHAR_W-1:0]    in_char_code,
  input  wire logic                 in_use_own_colors,
  input  wire logic [CLR_W-1:0]     in_item_fg,
  input  wire logic [CLR_W-1:0]     in_item_bg,
  input  wire logic [PROW_W-1:0]    in_read_row,
  input  wire logic [PCOL_W-1:0]    in_read_col,
  // towards queue and back end
  input  wire logic                 q_full,
  input  wire logic                 init_busy,
  output logic                      q_push,
  output cmd_t                      q_push_cmd,
  output logic [CLR_W-1:0]          def_fg,
  output logic [CLR_W-1:0]          def_bg
);

  logic [CLR_W-1:0] fg_r;
  logic [CLR_W-1:0] bg_r;
  logic             rd_in_range;

  // Colour registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= RST_FG;
      bg_r <= RST_BG;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FG:  fg_r <= cfg_data;
        CFG_BG:  bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign def_fg = fg_r;
  assign def_bg = bg_r;

  // Accept while the queue has room and the screen pass after reset is done
  assign in_stall = q_full || init_busy;
  assign q_push   = in_valid && !in_stall;

  assign rd_in_range = (int'(in_read_row) < ROW_COUNT) && (int'(in_read_col) < COLUMN_COUNT);

  // Classify the word into a back-end operation
  always_comb begin
    q_push_cmd.ch  = in_char_code;
    q_push_cmd.fg  = in_use_own_colors ? in_item_fg : fg_r;
    q_push_cmd.bg  = in_use_own_colors ? in_item_bg : bg_r;
    q_push_cmd.row = ROW_W'(in_read_row);
    q_push_cmd.col = COL_W'(in_read_col);
    case (in_mode)
      MODE_PUT: begin
        if (in_char_code == CHAR_NL) begin
          q_push_cmd.op = OP_NL;
        end else if (in_char_code == CHAR_CR) begin
          q_push_cmd.op = OP_CR;
        end else begin
          q_push_cmd.op = OP_PUT;
        end
      end
      MODE_READ:  q_push_cmd.op = rd_in_range ? OP_READ : OP_NOP;
      MODE_CLEAR: q_push_cmd.op = OP_CLEAR;
      default:    q_push_cmd.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/tcw_queue.sv]
`default_nettype none

module tcw_queue import tcw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output cmd_t      pop_cmd
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tcw_back.sv]
`default_nettype none

module tcw_back import tcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command queue
  input  wire logic              q_valid,
  input  wire cmd_t              q_cmd,
  output logic                   q_pop,
  input  wire logic [CLR_W-1:0]  def_fg,
  input  wire logic [CLR_W-1:0]  def_bg,
  output logic                   init_busy,
  // result word
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CHAR_W-1:0]      out_cell_char,
  output logic [CLR_W-1:0]       out_cell_fg,
  output logic [CLR_W-1:0]       out_cell_bg,
  output logic [PROW_W-1:0]      out_cursor_row,
  output logic [PCOL_W-1:0]      out_cursor_col,
  output logic [OFF_W-1:0]       out_cursor_offset,
  output logic                   out_scrolled
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;

  // Screen memory, physical row order
  cell_t mem [CELL_COUNT];
  cell_t rdata_r;

  logic [1:0]        state_r,     state_nxt;
  logic              init_r,      init_nxt;
  logic [ROW_W-1:0]  cur_row_r,   cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r,   cur_col_nxt;
  logic [ROW_W-1:0]  top_r,       top_nxt;
  logic [ADDR_W-1:0] fill_addr_r, fill_addr_nxt;
  logic [ADDR_W-1:0] fill_last_r, fill_last_nxt;
  cell_t             fill_cell_r, fill_cell_nxt;
  logic              out_valid_r, out_valid_nxt;

  cell_t             out_cell_r;
  logic [PROW_W-1:0] out_row_r;
  logic [PCOL_W-1:0] out_col_r;
  logic [OFF_W-1:0]  out_off_r;
  logic              out_scr_r;

  logic              out_free;
  logic              load_out;
  cell_t             res_cell;
  logic              res_scr;
  logic              do_break;
  logic              we;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  cell_t             wr_data;
  logic [ROW_W-1:0]  row_sel;
  logic [COL_W-1:0]  col_sel;
  logic [ROW_W1-1:0] prow_sum;
  logic [ROW_W-1:0]  prow;
  logic [ADDR_W-1:0] phys;
  logic              row_last;
  logic              col_last;
  logic [ROW_W-1:0]  top_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign init_busy = init_r;

  // Logical row/column to physical address through the ring offset
  assign row_sel  = (q_cmd.op == OP_READ) ? q_cmd.row : cur_row_r;
  assign col_sel  = (q_cmd.op == OP_READ) ? q_cmd.col : cur_col_r;
  assign prow_sum = ROW_W1'(row_sel) + ROW_W1'(top_r);
  assign prow     = (prow_sum >= ROW_W1'(ROW_COUNT)) ? ROW_W'(prow_sum - ROW_W1'(ROW_COUNT))
                                                     : ROW_W'(prow_sum);
  assign phys     = lin_index(prow, col_sel);

  assign row_last = (cur_row_r == ROW_W'(ROW_COUNT - 1));
  assign col_last = (cur_col_r == COL_W'(COLUMN_COUNT - 1));
  assign top_inc  = (top_r == ROW_W'(ROW_COUNT - 1)) ? '0 : top_r + ROW_W'(1);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    top_nxt       = top_r;
    fill_addr_nxt = fill_addr_r;
    fill_last_nxt = fill_last_r;
    fill_cell_nxt = fill_cell_r;
    q_pop         = 1'b0;
    load_out      = 1'b0;
    res_cell      = '0;
    res_scr       = 1'b0;
    do_break      = 1'b0;
    we            = 1'b0;
    rd_en         = 1'b0;
    wr_addr       = phys;
    wr_data       = make_cell(q_cmd.ch, q_cmd.fg, q_cmd.bg);

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == OP_READ) begin
            q_pop     = 1'b1;
            rd_en     = 1'b1;
            state_nxt = ST_READ;
          end else if (out_free) begin
            q_pop    = 1'b1;
            load_out = 1'b1;
            case (q_cmd.op)
              OP_PUT: begin
                we = 1'b1;
                if (col_last) begin
                  do_break = 1'b1;
                end else begin
                  cur_col_nxt = cur_col_r + COL_W'(1);
                end
              end
              OP_NL: do_break = 1'b1;
              OP_CR: cur_col_nxt = '0;
              OP_CLEAR: begin
                top_nxt       = '0;
                cur_row_nxt   = '0;
                cur_col_nxt   = '0;
                fill_addr_nxt = '0;
                fill_last_nxt = ADDR_W'(CELL_COUNT - 1);
                fill_cell_nxt = make_cell(CHAR_NUL, def_fg, def_bg);
                state_nxt     = ST_FILL;
              end
              default: ;
            endcase
            // line break, scrolling past the bottom row
            if (do_break) begin
              cur_col_nxt = '0;
              if (row_last) begin
                res_scr       = 1'b1;
                top_nxt       = top_inc;
                fill_addr_nxt = lin_index(top_r, '0);
                fill_last_nxt = lin_index(top_r, COL_W'(COLUMN_COUNT - 1));
                fill_cell_nxt = make_cell(CHAR_NUL, def_fg, def_bg);
                state_nxt     = ST_FILL;
              end else begin
                cur_row_nxt = cur_row_r + ROW_W'(1);
              end
            end
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          load_out  = 1'b1;
          res_cell  = rdata_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        we      = 1'b1;
        wr_addr = fill_addr_r;
        wr_data = fill_cell_r;
        if (fill_addr_r == fill_last_r) begin
          state_nxt = ST_IDLE;
          init_nxt  = 1'b0;
        end else begin
          fill_addr_nxt = fill_addr_r + ADDR_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output word handshake
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state; reset starts a pass that fills the screen with null cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      init_r      <= 1'b1;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      fill_addr_r <= '0;
      fill_last_r <= ADDR_W'(CELL_COUNT - 1);
      fill_cell_r <= make_cell(CHAR_NUL, RST_FG, RST_BG);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_last_r <= fill_last_nxt;
      fill_cell_r <= fill_cell_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cell_r <= res_cell;
      out_row_r  <= PROW_W'(cur_row_nxt);
      out_col_r  <= PCOL_W'(cur_col_nxt);
      out_off_r  <= OFF_W'(lin_index(cur_row_nxt, cur_col_nxt));
      out_scr_r  <= res_scr;
    end
  end

  // Screen memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[phys];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_char     = out_cell_r.ch;
  assign out_cell_fg       = out_cell_r.fg;
  assign out_cell_bg       = out_cell_r.bg;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_offset = out_off_r;
  assign out_scrolled      = out_scr_r;

endmodule

`default_nettype wire

[hw/rtl/text_console_writer_core.sv]
// Throughput: the back end takes one word per cycle for put, newline, return and unused
// modes while its result register is free; a cell read also passes a read state before its
// result is loaded, and a scroll refills the row and a clear the whole screen before the next
// word is taken, through the single memory write port.
// Reset: synchronous, active low; then a pass fills the screen memory with null
// cells (colour 7 on 0) while in_stall stays high; configuration writes are taken throughout.
`default_nettype none

module text_console_writer_core import tcw_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CLR_W-1:0]     cfg_data,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [MODE_W-1:0]    in_mode,
  input  wire logic [CHAR_W-1:0]    in_char_code,
  input  wire logic                 in_use_own_colors,
  input  wire logic [CLR_W-1:0]     in_item_fg,
  input  wire logic [CLR_W-1:0]     in_item_bg,
  input  wire logic [PROW_W-1:0]    in_read_row,
  input  wire logic [PCOL_W-1:0]    in_read_col,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CHAR_W-1:0]         out_cell_char,
  output logic [CLR_W-1:0]          out_cell_fg,
  output logic [CLR_W-1:0]          out_cell_bg,
  output logic [PROW_W-1:0]         out_cursor_row,
  output logic [PCOL_W-1:0]         out_cursor_col,
  output logic [OFF_W-1:0]          out_cursor_offset,
  output logic                      out_scrolled
);

  logic             q_full;
  logic             q_push;
  cmd_t             q_push_cmd;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             init_busy;
  logic [CLR_W-1:0] def_fg;
  logic [CLR_W-1:0] def_bg;

  // Front: registers and word classification
  tcw_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_char_code      (in_char_code),
    .in_use_own_colors (in_use_own_colors),
    .in_item_fg        (in_item_fg),
    .in_item_bg        (in_item_bg),
    .in_read_row       (in_read_row),
    .in_read_col       (in_read_col),
    .q_full            (q_full),
    .init_busy         (init_busy),
    .q_push            (q_push),
    .q_push_cmd        (q_push_cmd),
    .def_fg            (def_fg),
    .def_bg            (def_bg)
  );

  // Command queue between front and back
  tcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  // Back: cursor, screen memory, scroll and clear fills, result register
  tcw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .def_fg            (def_fg),
    .def_bg            (def_bg),
    .init_busy         (init_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_char     (out_cell_char),
    .out_cell_fg       (out_cell_fg),
    .out_cell_bg       (out_cell_bg),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_offset (out_cursor_offset),
    .out_scrolled      (out_scrolled)
  );

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  // The mode code that the block leaves unused
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 200;
  localparam int DIRECTED_ROWS  = 25;
  // A clear keeps refilling the screen memory after its result word has left
  localparam int SETTLE_CYCLES  = CELL_COUNT + 64;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic              use_own;
    logic [CLR_W-1:0]  item_fg;
    logic [CLR_W-1:0]  item_bg;
    logic [PROW_W-1:0] read_row;
    logic [PCOL_W-1:0] read_col;
  } word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [CLR_W-1:0]  cell_fg;
    logic [CLR_W-1:0]  cell_bg;
    logic [PROW_W-1:0] cursor_row;
    logic [PCOL_W-1:0] cursor_col;
    logic [OFF_W-1:0]  cursor_offset;
    logic              scrolled;
  } report_t;

  typedef struct packed {
    word_t   w;
    logic    fixed;
    report_t want;
  } script_row_t;

  localparam report_t BLANK_REPORT = '0;
  // untouched cell at home position, colours as after reset
  localparam report_t RESET_CELL =
    '{CHAR_NUL, RST_FG, RST_BG, 5'd0, 7'd0, 11'd0, 1'b0};

  // Directed words; fixed rows carry their result, the rest go through the screen model
  localparam script_row_t SCRIPT [DIRECTED_ROWS] = '{
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd0,  7'd0},   1'b1, RESET_CELL},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd24, 7'd79},  1'b1, RESET_CELL},
    '{'{MODE_READ,  8'hFF,    1'b1, 4'hF, 4'hF, 5'd31, 7'd127}, 1'b1, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd25, 7'd0},   1'b1, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd0,  7'd80},  1'b1, BLANK_REPORT},
    '{'{MODE_SPARE, 8'hFF,    1'b1, 4'hF, 4'hF, 5'd31, 7'd127}, 1'b1, BLANK_REPORT},
    '{'{MODE_PUT,   8'h41,    1'b0, 4'hF, 4'hF, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_PUT,   CHAR_NUL, 1'b1, 4'hF, 4'hF, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_PUT,   8'hFF,    1'b1, 4'h0, 4'h0, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_PUT,   8'h1B,    1'b0, 4'h0, 4'h0, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd0,  7'd1},   1'b0, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd0,  7'd2},   1'b0, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd0,  7'd3},   1'b0, BLANK_REPORT},
    '{'{MODE_PUT,   CHAR_CR,  1'b1, 4'hF, 4'hF, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_PUT,   8'h42,    1'b1, 4'h5, 4'hA, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_PUT,   CHAR_NL,  1'b0, 4'h0, 4'h0, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_PUT,   CHAR_NL,  1'b1, 4'hF, 4'hF, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_PUT,   8'h7E,    1'b1, 4'hF, 4'h0, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd2,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_SPARE, CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd0,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_CLEAR, 8'hFF,    1'b1, 4'hF, 4'hF, 5'd31, 7'd127}, 1'b1, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd2,  7'd0},   1'b0, BLANK_REPORT},
    '{'{MODE_READ,  CHAR_NUL, 1'b0, 4'h0, 4'h0, 5'd0,  7'd0},   1'b1, RESET_CELL}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CLR_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [MODE_W-1:0]    in_mode;
  logic [CHAR_W-1:0]    in_char_code;
  logic                 in_use_own_colors;
  logic [CLR_W-1:0]     in_item_fg;
  logic [CLR_W-1:0]     in_item_bg;
  logic [PROW_W-1:0]    in_read_row;
  logic [PCOL_W-1:0]    in_read_col;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    out_cell_char;
  logic [CLR_W-1:0]     out_cell_fg;
  logic [CLR_W-1:0]     out_cell_bg;
  logic [PROW_W-1:0]    out_cursor_row;
  logic [PCOL_W-1:0]    out_cursor_col;
  logic [OFF_W-1:0]     out_cursor_offset;
  logic                 out_scrolled;

  text_console_writer_core i_dut (.*);

  // Screen model state
  cell_t            screen_mem [CELL_COUNT];
  int unsigned      ring_top;
  int unsigned      cur_row;
  int unsigned      cur_col;
  logic [CLR_W-1:0] reg_fg;
  logic [CLR_W-1:0] reg_bg;

  report_t     expected_reports [$];
  int unsigned failures     = 0;
  int unsigned words_sent   = 0;
  int unsigned scroll_count = 0;
  int unsigned read_count   = 0;
  int unsigned clear_count  = 0;
  bit          in_idle_on   = 1'b0;
  bit          out_idle_on  = 1'b0;
  int unsigned stall_left   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- screen model
  function automatic int unsigned cell_addr(int unsigned row, int unsigned col);
    return ((row + ring_top) % ROW_COUNT) * COLUMN_COUNT + col;
  endfunction

  function automatic void blank_screen();
    cell_t nul;
    nul.ch = CHAR_NUL;
    nul.fg = reg_fg;
    nul.bg = reg_bg;
    foreach (screen_mem[i]) screen_mem[i] = nul;
  endfunction

  // next row; past the bottom the ring moves on and the new bottom row is blanked
  function automatic bit advance_line();
    cell_t       nul;
    int unsigned base;
    bit          rolled;
    rolled = 1'b0;
    cur_row++;
    if (cur_row >= ROW_COUNT) begin
      cur_row  = ROW_COUNT - 1;
      ring_top = (ring_top + 1) % ROW_COUNT;
      base     = ((ring_top + ROW_COUNT - 1) % ROW_COUNT) * COLUMN_COUNT;
      nul.ch   = CHAR_NUL;
      nul.fg   = reg_fg;
      nul.bg   = reg_bg;
      for (int c = 0; c < COLUMN_COUNT; c++) screen_mem[base + c] = nul;
      rolled = 1'b1;
      scroll_count++;
    end
    cur_col = 0;
    return rolled;
  endfunction

  task automatic apply_to_screen(input word_t w, output report_t rep);
    cell_t c;
    bit    rolled;
    rolled = 1'b0;
    rep    = '0;
    case (w.mode)
      MODE_PUT: begin
        if (w.char_code == CHAR_NL) begin
          rolled = advance_line();
        end else if (w.char_code == CHAR_CR) begin
          cur_col = 0;
        end else begin
          c.ch = w.char_code;
          c.fg = w.use_own ? w.item_fg : reg_fg;
          c.bg = w.use_own ? w.item_bg : reg_bg;
          screen_mem[cell_addr(cur_row, cur_col)] = c;
          cur_col++;
          if (cur_col >= COLUMN_COUNT) rolled = advance_line();
        end
      end
      MODE_READ: begin
        if (w.read_row < ROW_COUNT && w.read_col < COLUMN_COUNT) begin
          c = screen_mem[cell_addr(w.read_row, w.read_col)];
          rep.cell_char = c.ch;
          rep.cell_fg   = c.fg;
          rep.cell_bg   = c.bg;
          read_count++;
        end
      end
      MODE_CLEAR: begin
        blank_screen();
        ring_top = 0;
        cur_row  = 0;
        cur_col  = 0;
        clear_count++;
      end
      default: ;
    endcase
    rep.cursor_row    = PROW_W'(cur_row);
    rep.cursor_col    = PCOL_W'(cur_col);
    rep.cursor_offset = OFF_W'(cur_row * COLUMN_COUNT + cur_col);
    rep.scrolled      = rolled;
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_word(input word_t w, input bit fixed, input report_t want);
    int unsigned gap;
    report_t     rep;
    gap = in_idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= w.mode;
    in_char_code      <= w.char_code;
    in_use_own_colors <= w.use_own;
    in_item_fg        <= w.item_fg;
    in_item_bg        <= w.item_bg;
    in_read_row       <= w.read_row;
    in_read_col       <= w.read_col;
    do @(posedge clk); while (!(in_valid && !in_stall));
    apply_to_screen(w, rep);
    expected_reports.push_back(fixed ? want : rep);
    words_sent++;
  endtask

  // both colour registers back to back, valid held high across the pair
  task automatic set_colours(input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FG;
    cfg_data  <= fg;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    reg_fg = fg;
    cfg_index <= CFG_BG;
    cfg_data  <= bg;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    reg_bg = bg;
    cfg_valid <= 1'b0;
  endtask

  // every field random, mode imposed
  function automatic word_t noise_word(input logic [MODE_W-1:0] mode);
    word_t w;
    w.mode      = mode;
    w.char_code = CHAR_W'($urandom);
    w.use_own   = 1'($urandom);
    w.item_fg   = CLR_W'($urandom);
    w.item_bg   = CLR_W'($urandom);
    w.read_row  = PROW_W'($urandom);
    w.read_col  = PCOL_W'($urandom);
    return w;
  endfunction

  // mostly in range, biased to the cursor row; now and then any address at all
  function automatic word_t read_word();
    word_t       w;
    int unsigned pick;
    w    = noise_word(MODE_READ);
    pick = $urandom_range(0, 9);
    if (pick != 0) begin
      w.read_row = (pick < 6) ? PROW_W'(cur_row) : PROW_W'($urandom_range(0, ROW_COUNT - 1));
      w.read_col = PCOL_W'($urandom_range(0, COLUMN_COUNT - 1));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------- result side
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("result word with nothing outstanding");
        failures++;
      end else begin
        want = expected_reports.pop_front();
        check_field("cell_char", want.cell_char, out_cell_char);
        check_field("cell_fg", want.cell_fg, out_cell_fg);
        check_field("cell_bg", want.cell_bg, out_cell_bg);
        check_field("cursor_row", want.cursor_row, out_cursor_row);
        check_field("cursor_col", want.cursor_col, out_cursor_col);
        check_field("cursor_offset", want.cursor_offset, out_cursor_offset);
        check_field("scrolled", want.scrolled, out_scrolled);
      end
    end
  end

  // random stall after each result word taken, while out_idle_on is set
  always @(posedge clk) begin : result_pacing
    if (out_valid && !out_stall) begin
      stall_left = out_idle_on ? $urandom_range(0, 4) : 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // watchdog: too long without any handshake
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("text_console_writer_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    word_t            w;
    int unsigned      sent;
    int unsigned      kind;
    int unsigned      span;
    int unsigned      pick;
    logic [CLR_W-1:0] fg;
    logic [CLR_W-1:0] bg;

    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_FG;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_mode           = MODE_PUT;
    in_char_code      = CHAR_NUL;
    in_use_own_colors = 1'b0;
    in_item_fg        = '0;
    in_item_bg        = '0;
    in_read_row       = '0;
    in_read_col       = '0;

    reg_fg   = RST_FG;
    reg_bg   = RST_BG;
    ring_top = 0;
    cur_row  = 0;
    cur_col  = 0;
    blank_screen();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset colours
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      in_idle_on  = (i % 2) != 0;
      out_idle_on = (i % 3) != 0;
      send_word(SCRIPT[i].w, SCRIPT[i].fixed, SCRIPT[i].want);
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // drain, let any clear finish its refill, then recolour
      while (expected_reports.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph)
        0: begin fg = 4'hF; bg = 4'hF; end
        1: begin fg = 4'h0; bg = 4'h0; end
        2: begin fg = 4'h0; bg = 4'hF; end
        3: begin fg = 4'hF; bg = 4'h0; end
        default: begin fg = CLR_W'($urandom); bg = CLR_W'($urandom); end
      endcase
      set_colours(fg, bg);

      sent = 0;
      if ($urandom_range(0, 1) != 0) begin
        send_word(noise_word(MODE_CLEAR), 1'b0, BLANK_REPORT);
        sent++;
      end

      // bursts of well-formed traffic with random content
      while (sent < PHASE_WORDS) begin
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
          send_word(noise_word(MODE_CLEAR), 1'b0, BLANK_REPORT);
          sent++;
        end else if (kind < 40) begin
          // mixed lines: text, line ends, returns, reads and the odd unused mode
          span = $urandom_range(5, 40);
          for (int k = 0; k < span; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
              w = noise_word(MODE_PUT);
              w.char_code = CHAR_NL;
            end else if (pick < 11) begin
              w = noise_word(MODE_PUT);
              w.char_code = CHAR_CR;
            end else if (pick < 14) begin
              w = noise_word(MODE_SPARE);
            end else if (pick < 30) begin
              w = read_word();
            end else begin
              w = noise_word(MODE_PUT);
            end
            send_word(w, 1'b0, BLANK_REPORT);
          end
          sent += span;
        end else if (kind < 55) begin
          // long text runs past the last column
          span = $urandom_range(80, 200);
          for (int k = 0; k < span; k++) begin
            w = noise_word(MODE_PUT);
            if (w.char_code == CHAR_NL) w.char_code = 8'h2E;
            send_word(w, 1'b0, BLANK_REPORT);
          end
          sent += span;
        end else if (kind < 75) begin
          // runs of line ends, scrolling once per line end at the bottom
          span = $urandom_range(5, 30);
          for (int k = 0; k < span; k++) begin
            w = noise_word(MODE_PUT);
            w.char_code = CHAR_NL;
            send_word(w, 1'b0, BLANK_REPORT);
          end
          sent += span;
        end else begin
          span = $urandom_range(5, 30);
          for (int k = 0; k < span; k++) send_word(read_word(), 1'b0, BLANK_REPORT);
          sent += span;
        end
      end
      in_valid <= 1'b0;
    end

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d result words never arrived", expected_reports.size());
      failures++;
    end

    $display("Sent %0d words over %0d colour settings: %0d in-range cell reads,",
             words_sent, PHASES + 1, read_count);
    $display("%0d scrolls and %0d screen clears; %0d mismatches.",
             scroll_count, clear_count, failures);
    if (failures == 0) begin
      $display("text_console_writer_core test passed");
    end else begin
      $display("text_console_writer_core test failed");
    end
    $finish;
  end

endmodule
